FILE: rtl/core/assert_macros.svh
// assertion macros included by the parser unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// whenever cond holds, prop holds in the same cycle
`define SFP_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed: same-cycle implication");

// whenever cond holds, prop holds in the next cycle
`define SFP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle implication");

`else

`define SFP_ASSERT_IMPL(label, clk, rst_n, cond, prop)
`define SFP_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

FILE: rtl/core/sfp_pkg.sv
// constants and types of the sensor frame parser
`default_nettype none

package sfp_pkg;

  localparam int SENSOR_COUNT        = 8;
  localparam int RECEIVE_BUFFER_SIZE = 200;
  localparam int FRAME_SPAN_LIMIT    = 60;

  // outputs always carry eight sensor slots
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);

  localparam logic [7:0] CH_START  = 8'h24;  // '$'
  localparam logic [7:0] CH_HEADER = 8'h44;  // 'D'
  localparam logic [7:0] CH_END    = 8'h23;  // '#'
  localparam logic [7:0] CH_COLON  = 8'h3A;  // ':'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CH_X      = 8'h78;  // 'x'
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [7:0] BYTES_LIMIT = 8'(RECEIVE_BUFFER_SIZE - 1);
  localparam logic [7:0] SPAN_MAX    = 8'(FRAME_SPAN_LIMIT - 2);
  localparam logic [3:0] STAGE_MAX   = 4'(SENSOR_COUNT);

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_NO_START   = 3'd1,
    ST_TOO_LONG   = 3'd2,
    ST_BAD_HEADER = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    COLON_NONE  = 2'd0,
    COLON_JUST  = 2'd1,
    COLON_TAKEN = 2'd2
  } colon_t;

endpackage

`default_nettype wire

FILE: rtl/core/sensor_frame_parser_unit.sv
// sensor frame parser: one received byte per beat, a result beat per frame end or overflow
// a result beat appears in the cycle after the input beat that causes it
// throughput: one input beat per cycle; input stalls only while a result beat is held
// values are the stored sensor values after the causing byte
// reset (rst_n low, synchronous) clears the frame state, stored values and output valid
`default_nettype none

`include "assert_macros.svh"

module sensor_frame_parser_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sfp_pkg::status_t          out_status,
  output logic [3:0]                out_values_found,
  output logic [7:0]                out_value_0,
  output logic [7:0]                out_value_1,
  output logic [7:0]                out_value_2,
  output logic [7:0]                out_value_3,
  output logic [7:0]                out_value_4,
  output logic [7:0]                out_value_5,
  output logic [7:0]                out_value_6,
  output logic [7:0]                out_value_7
);
  import sfp_pkg::*;

  // frame state
  logic [7:0] bytes_stored_r, bytes_stored_nxt;
  logic       start_seen_r, start_seen_nxt;
  logic [7:0] offset_r, offset_nxt;
  logic       header_ok_r, header_ok_nxt;
  logic       stopped_r, stopped_nxt;
  logic       tok_x_r, tok_x_nxt;
  colon_t     tok_colon_r, tok_colon_nxt;
  logic [7:0] tok_val_r, tok_val_nxt;
  logic [3:0] staged_count_r, staged_count_nxt;

  logic [7:0] staged_r [NUM_SLOTS];
  logic [7:0] staged_view [NUM_SLOTS];
  logic [7:0] stored_r [NUM_SLOTS];
  logic [7:0] stored_nxt [NUM_SLOTS];

  // output register
  logic       out_valid_r;
  status_t    out_status_r;
  logic [3:0] out_found_r;

  logic            in_accept;
  logic            emit;
  status_t         status_c;
  logic [3:0]      found_c;
  logic            stage_we;
  logic [SLOT_IDX_W-1:0] stage_idx;
  logic [7:0]      stage_data;
  logic [7:0]      off_inc;
  logic            feed_on;
  logic            do_finish;
  logic [7:0]      fin_val;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    bytes_stored_nxt = bytes_stored_r;
    start_seen_nxt   = start_seen_r;
    offset_nxt       = offset_r;
    header_ok_nxt    = header_ok_r;
    stopped_nxt      = stopped_r;
    tok_x_nxt        = tok_x_r;
    tok_colon_nxt    = tok_colon_r;
    tok_val_nxt      = tok_val_r;
    staged_count_nxt = staged_count_r;
    emit             = 1'b0;
    status_c         = ST_ACCEPTED;
    found_c          = 4'd0;
    stage_we         = 1'b0;
    stage_idx        = staged_count_r[SLOT_IDX_W-1:0];
    stage_data       = 8'd0;
    off_inc          = (offset_r == 8'hFF) ? offset_r : offset_r + 8'd1;
    feed_on          = start_seen_r & ~stopped_r;
    do_finish        = 1'b0;
    fin_val          = 8'd0;

    if (bytes_stored_r >= BYTES_LIMIT) begin
      // byte dropped, frame restarts
      emit             = 1'b1;
      status_c         = ST_OVERFLOW;
      bytes_stored_nxt = 8'd0;
      start_seen_nxt   = 1'b0;
      offset_nxt       = 8'd0;
      header_ok_nxt    = 1'b0;
      stopped_nxt      = 1'b0;
      tok_x_nxt        = 1'b0;
      tok_colon_nxt    = COLON_NONE;
      tok_val_nxt      = 8'd0;
      staged_count_nxt = 4'd0;
    end else begin
      bytes_stored_nxt = bytes_stored_r + 8'd1;
      if (!start_seen_r) begin
        if (in_rx_byte == CH_START) begin
          start_seen_nxt = 1'b1;
        end
      end else begin
        offset_nxt = off_inc;
        if (off_inc == 8'd1 && in_rx_byte == CH_HEADER) begin
          header_ok_nxt = 1'b1;
        end
      end

      // while the feed is on, any byte but a comma or zero byte updates the token
      if (feed_on && in_rx_byte != CH_NUL && in_rx_byte != CH_COMMA) begin
        if (in_rx_byte == CH_X) begin
          tok_x_nxt = 1'b1;
        end
        if (tok_colon_r == COLON_NONE) begin
          if (in_rx_byte == CH_COLON) begin
            tok_colon_nxt = COLON_JUST;
          end
        end else if (tok_colon_r == COLON_JUST) begin
          tok_val_nxt   = in_rx_byte - CH_ZERO;
          tok_colon_nxt = COLON_TAKEN;
        end
      end

      // comma, zero byte or frame end closes the token
      do_finish = feed_on &&
                  (in_rx_byte == CH_NUL || in_rx_byte == CH_COMMA || in_rx_byte == CH_END);
      if (do_finish) begin
        fin_val = (tok_colon_nxt == COLON_JUST) ? (CH_NUL - CH_ZERO) : tok_val_nxt;
        if (tok_x_nxt && tok_colon_nxt != COLON_NONE && staged_count_r < STAGE_MAX) begin
          stage_we         = 1'b1;
          stage_data       = fin_val;
          staged_count_nxt = staged_count_r + 4'd1;
        end
        tok_x_nxt     = 1'b0;
        tok_colon_nxt = COLON_NONE;
        tok_val_nxt   = 8'd0;
        if (in_rx_byte == CH_NUL) begin
          stopped_nxt = 1'b1;
        end
      end

      if (in_rx_byte == CH_END) begin
        emit = 1'b1;
        if (!start_seen_r) begin
          status_c = ST_NO_START;
        end else if (offset_nxt > SPAN_MAX) begin
          status_c = ST_TOO_LONG;
        end else if (!header_ok_nxt) begin
          status_c = ST_BAD_HEADER;
        end else begin
          status_c = ST_ACCEPTED;
          found_c  = staged_count_nxt;
        end
        bytes_stored_nxt = 8'd0;
        start_seen_nxt   = 1'b0;
        offset_nxt       = 8'd0;
        header_ok_nxt    = 1'b0;
        stopped_nxt      = 1'b0;
        tok_x_nxt        = 1'b0;
        tok_colon_nxt    = COLON_NONE;
        tok_val_nxt      = 8'd0;
        staged_count_nxt = 4'd0;
      end
    end
  end

  // staged values including this beat's write, copied on an accepted frame
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      staged_view[i] = (stage_we && stage_idx == SLOT_IDX_W'(i)) ? stage_data : staged_r[i];
      stored_nxt[i]  = stored_r[i];
      if (emit && status_c == ST_ACCEPTED && 4'(i) < found_c) begin
        stored_nxt[i] = staged_view[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_stored_r <= 8'd0;
      start_seen_r   <= 1'b0;
      offset_r       <= 8'd0;
      header_ok_r    <= 1'b0;
      stopped_r      <= 1'b0;
      tok_x_r        <= 1'b0;
      tok_colon_r    <= COLON_NONE;
      tok_val_r      <= 8'd0;
      staged_count_r <= 4'd0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        stored_r[i] <= 8'd0;
      end
    end else if (in_accept) begin
      bytes_stored_r <= bytes_stored_nxt;
      start_seen_r   <= start_seen_nxt;
      offset_r       <= offset_nxt;
      header_ok_r    <= header_ok_nxt;
      stopped_r      <= stopped_nxt;
      tok_x_r        <= tok_x_nxt;
      tok_colon_r    <= tok_colon_nxt;
      tok_val_r      <= tok_val_nxt;
      staged_count_r <= staged_count_nxt;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        stored_r[i] <= stored_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && stage_we) begin
      staged_r[stage_idx] <= stage_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= in_accept & emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_status_r <= status_c;
      out_found_r  <= found_c;
    end
  end

  // stored values only move on an accepted beat, which needs the result slot free
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_values_found = out_found_r;
  assign out_value_0      = stored_r[0];
  assign out_value_1      = stored_r[1];
  assign out_value_2      = stored_r[2];
  assign out_value_3      = stored_r[3];
  assign out_value_4      = stored_r[4];
  assign out_value_5      = stored_r[5];
  assign out_value_6      = stored_r[6];
  assign out_value_7      = stored_r[7];

  `SFP_ASSERT_IMPL(a_stage_bound, clk, rst_n, 1'b1, staged_count_r <= STAGE_MAX)
  `SFP_ASSERT_IMPL(a_bytes_bound, clk, rst_n, 1'b1, bytes_stored_r <= BYTES_LIMIT)
  `SFP_ASSERT_IMPL(a_idle_frame, clk, rst_n, !start_seen_r, offset_r == 8'd0 && staged_count_r == 4'd0)
  `SFP_ASSERT_NEXT(a_end_result, clk, rst_n, in_accept && in_rx_byte == CH_END, out_valid_r)
  `SFP_ASSERT_IMPL(a_found_reject, clk, rst_n, out_valid_r && out_status_r != ST_ACCEPTED, out_found_r == 4'd0)

endmodule

`default_nettype wire
